[rtl/averaging_sample_logger_assert.svh]
// Assertion macros for the averaging sample logger RTL.
// Needs clk and rst in scope at the point of use; empty under SYNTHESIS.
`ifndef AVERAGING_SAMPLE_LOGGER_ASSERT_SVH
`define AVERAGING_SAMPLE_LOGGER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ASL_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("asl assertion failed: same-cycle implication");
// Next-cycle implication.
`define ASL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("asl assertion failed: next-cycle implication");
`else
`define ASL_ASSERT_IMPLY(label, ante, cons)
`define ASL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/asl_pkg.sv]
// Shared types and constants of the averaging sample logger.
// No dependencies; used by every module of the block.
`default_nettype none

package asl_pkg;

  localparam int CHANNELS  = 7;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SMP_W     = 16;
  localparam int MIN_W     = 6;
  localparam int CNT_W     = 8;

  // Divider: dividend holds 2*|delta| (17 bits) padded to an even width.
  localparam int DVD_W     = 18;
  localparam int DVS_W     = 9;
  localparam int DIV_STEPS = 2;
  localparam int DIV_ITER  = DVD_W / DIV_STEPS;
  localparam int DIV_CNT_W = $clog2(DIV_ITER);

  localparam logic [CNT_W-1:0] CNT_MAX  = 8'hFF;
  localparam logic [MIN_W:0]   MIN_LAST = 7'd59;
  localparam logic [MIN_W:0]   MIN_WRAP = 7'd60;
  localparam logic [MIN_W-1:0] SMP_IV_RST = 6'd5;
  localparam logic [MIN_W-1:0] SAV_IV_RST = 6'd30;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_POLL  = 1'b1;

  localparam logic CFG_SAMPLE_IV = 1'b0;
  localparam logic CFG_SAVE_IV   = 1'b1;

  typedef logic [CHANNELS-1:0][SMP_W-1:0] smp_vec_t;

  typedef enum logic [1:0] {
    DIV_MARK_SMP = 2'd0,
    DIV_MARK_SAV = 2'd1,
    DIV_FOLD     = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     load_item;
    logic     div_start;
    div_sel_t div_sel;
    logic     mark_smp_write;
    logic     mark_sav_write;
    logic     start_finish;
    logic     mean_write;
    logic     ch_next;
    logic     fold_finish;
    logic     emit;
  } asl_cmd_t;

  typedef struct packed {
    logic is_start;
    logic active;
    logic hit_sample;
    logic hit_save;
    logic div_done;
    logic last_ch;
    logic out_free;
  } asl_sts_t;

endpackage

`default_nettype wire

[rtl/asl_div.sv]
// Restoring unsigned divider, DIV_STEPS quotient bits per cycle.
// Depends on asl_pkg for widths.
`default_nettype none

module asl_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [asl_pkg::DVD_W-1:0]   dividend,
  input  wire logic [asl_pkg::DVS_W-1:0]   divisor,
  output logic                             busy,
  output logic                             done,
  output logic [asl_pkg::DVD_W-1:0]        quotient,
  output logic [asl_pkg::DVS_W-1:0]        remainder
);

  logic [asl_pkg::DVS_W-1:0]     rem;
  logic [asl_pkg::DVD_W-1:0]     quo;
  logic [asl_pkg::DVS_W-1:0]     dvs;
  logic [asl_pkg::DIV_CNT_W-1:0] cnt;

  logic [asl_pkg::DVS_W-1:0] rem_s [asl_pkg::DIV_STEPS+1];
  logic [asl_pkg::DVD_W-1:0] quo_s [asl_pkg::DIV_STEPS+1];
  logic [asl_pkg::DVS_W:0]   trial [asl_pkg::DIV_STEPS];

  // Shift in one dividend bit, subtract when it fits.
  always_comb begin
    rem_s[0] = rem;
    quo_s[0] = quo;
    for (int k = 0; k < asl_pkg::DIV_STEPS; k++) begin
      trial[k] = {rem_s[k], quo_s[k][asl_pkg::DVD_W-1]};
      if (trial[k] >= {1'b0, dvs}) begin
        rem_s[k+1] = asl_pkg::DVS_W'(trial[k] - {1'b0, dvs});
        quo_s[k+1] = {quo_s[k][asl_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_s[k+1] = trial[k][asl_pkg::DVS_W-1:0];
        quo_s[k+1] = {quo_s[k][asl_pkg::DVD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == asl_pkg::DIV_CNT_W'(asl_pkg::DIV_ITER - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == asl_pkg::DIV_CNT_W'(asl_pkg::DIV_ITER - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_s[asl_pkg::DIV_STEPS];
      quo <= quo_s[asl_pkg::DIV_STEPS];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

[rtl/asl_dp.sv]
// Datapath: item latch, interval registers, running means, targets,
// shared divider and the record output register. Depends on asl_pkg, asl_div and the assertion header.
`default_nettype none
`include "averaging_sample_logger_assert.svh"

module asl_dp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire asl_pkg::asl_cmd_t           cmd,
  output asl_pkg::asl_sts_t                sts,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [asl_pkg::MIN_W-1:0]   cfg_data,
  input  wire logic                        req_type,
  input  wire logic [3:0]                  month,
  input  wire logic [4:0]                  day,
  input  wire logic [4:0]                  hour,
  input  wire logic [asl_pkg::MIN_W-1:0]   minute,
  input  wire asl_pkg::smp_vec_t           samples,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [3:0]                       rec_month,
  output logic [4:0]                       rec_day,
  output logic [4:0]                       rec_hour,
  output logic [asl_pkg::MIN_W-1:0]        rec_minute,
  output asl_pkg::smp_vec_t                rec_mean
);

  function automatic logic [asl_pkg::MIN_W-1:0] eff_iv(input logic [asl_pkg::MIN_W-1:0] iv);
    return (iv == '0) ? asl_pkg::MIN_W'(1) : iv;
  endfunction

  function automatic logic [asl_pkg::MIN_W-1:0] adv(input logic [asl_pkg::MIN_W-1:0] t,
                                                      input logic [asl_pkg::MIN_W-1:0] iv);
    logic [asl_pkg::MIN_W:0] s;
    s = {1'b0, t} + {1'b0, iv};
    if (s > asl_pkg::MIN_LAST) s = s - asl_pkg::MIN_WRAP;
    return s[asl_pkg::MIN_W-1:0];
  endfunction

  // Round the minute up to the next multiple: minute - minute % iv + iv.
  function automatic logic [asl_pkg::MIN_W-1:0] mark(input logic [asl_pkg::MIN_W-1:0] m,
                                                       input logic [asl_pkg::MIN_W-1:0] r,
                                                       input logic [asl_pkg::MIN_W-1:0] iv);
    logic [asl_pkg::MIN_W:0] s;
    s = {1'b0, m} - {1'b0, r} + {1'b0, iv};
    return (s > asl_pkg::MIN_LAST) ? '0 : s[asl_pkg::MIN_W-1:0];
  endfunction

  logic [asl_pkg::MIN_W-1:0] sample_iv;
  logic [asl_pkg::MIN_W-1:0] save_iv;
  logic                      req_q;
  logic [3:0]                month_q;
  logic [4:0]                day_q;
  logic [4:0]                hour_q;
  logic [asl_pkg::MIN_W-1:0] minute_q;
  asl_pkg::smp_vec_t         smp_q;
  asl_pkg::smp_vec_t         mean_q;
  logic [asl_pkg::CNT_W-1:0] count;
  logic [asl_pkg::MIN_W-1:0] next_smp;
  logic [asl_pkg::MIN_W-1:0] next_sav;
  logic                      active;
  logic [asl_pkg::CH_W-1:0]  ch;

  logic [asl_pkg::MIN_W-1:0] si;
  logic [asl_pkg::MIN_W-1:0] sv;
  logic [asl_pkg::SMP_W-1:0] cur_mean;
  logic [asl_pkg::SMP_W-1:0] cur_smp;
  logic                      up;
  logic [asl_pkg::SMP_W-1:0] mag;
  logic [asl_pkg::DVD_W-1:0] dividend;
  logic [asl_pkg::DVS_W-1:0] divisor;
  logic                      div_busy;
  logic                      div_done;
  logic [asl_pkg::DVD_W-1:0] quo;
  logic [asl_pkg::DVS_W-1:0] rem;
  logic [asl_pkg::DVD_W:0]   quo_inc;
  logic [asl_pkg::SMP_W-1:0] step;
  logic [asl_pkg::SMP_W-1:0] mean_new;
  logic [asl_pkg::MIN_W-1:0] mark_smp;
  logic [asl_pkg::MIN_W-1:0] mark_sav;

  assign si       = eff_iv(sample_iv);
  assign sv       = eff_iv(save_iv);
  assign cur_mean = mean_q[ch];
  assign cur_smp  = smp_q[ch];
  assign up       = (cur_smp >= cur_mean);
  assign mag      = up ? (cur_smp - cur_mean) : (cur_mean - cur_smp);

  always_comb begin
    unique case (cmd.div_sel)
      asl_pkg::DIV_FOLD: begin
        dividend = {1'b0, mag, 1'b0};
        divisor  = {1'b0, count} + 1'b1;
      end
      asl_pkg::DIV_MARK_SAV: begin
        dividend = asl_pkg::DVD_W'(minute_q);
        divisor  = asl_pkg::DVS_W'(sv);
      end
      default: begin
        dividend = asl_pkg::DVD_W'(minute_q);
        divisor  = asl_pkg::DVS_W'(si);
      end
    endcase
  end

  asl_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (dividend),
    .divisor   (divisor),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  // Round half away from zero: (q + 1) >> 1 on the doubled magnitude.
  assign quo_inc  = {1'b0, quo} + 1'b1;
  assign step     = quo_inc[asl_pkg::SMP_W:1];
  assign mean_new = up ? (cur_mean + step) : (cur_mean - step);
  assign mark_smp = mark(minute_q, rem[asl_pkg::MIN_W-1:0], si);
  assign mark_sav = mark(minute_q, rem[asl_pkg::MIN_W-1:0], sv);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_iv <= asl_pkg::SMP_IV_RST;
      save_iv   <= asl_pkg::SAV_IV_RST;
      mean_q    <= '0;
      count     <= '0;
      next_smp  <= '0;
      next_sav  <= '0;
      active    <= 1'b0;
      ch        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          asl_pkg::CFG_SAMPLE_IV: sample_iv <= cfg_data;
          asl_pkg::CFG_SAVE_IV:   save_iv   <= cfg_data;
          default:                sample_iv <= sample_iv;
        endcase
      end
      if (cmd.load_item) ch <= '0;
      if (cmd.mark_smp_write) next_smp <= mark_smp;
      if (cmd.mark_sav_write) next_sav <= mark_sav;
      if (cmd.start_finish) begin
        count  <= '0;
        active <= 1'b1;
      end
      if (cmd.mean_write) mean_q[ch] <= mean_new;
      if (cmd.ch_next) ch <= ch + 1'b1;
      if (cmd.fold_finish) begin
        if (count != asl_pkg::CNT_MAX) count <= count + 1'b1;
        next_smp <= adv(next_smp, si);
      end
      if (cmd.emit) begin
        next_sav  <= adv(next_sav, sv);
        count     <= '0;
        mean_q    <= '0;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: item latch and record.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      req_q    <= req_type;
      month_q  <= month;
      day_q    <= day;
      hour_q   <= hour;
      minute_q <= minute;
      smp_q    <= samples;
    end
    if (cmd.emit) begin
      rec_month  <= month_q;
      rec_day    <= day_q;
      rec_hour   <= hour_q;
      rec_minute <= minute_q;
      rec_mean   <= mean_q;
    end
  end

  assign sts.is_start   = (req_q == asl_pkg::REQ_START);
  assign sts.active     = active;
  assign sts.hit_sample = (minute_q == next_smp);
  assign sts.hit_save   = (minute_q == next_sav);
  assign sts.div_done   = div_done;
  assign sts.last_ch    = (ch == asl_pkg::CH_W'(asl_pkg::CHANNELS - 1));
  assign sts.out_free   = !out_valid || out_ready;

  `ASL_ASSERT_IMPLY(a_div_idle_at_start, cmd.div_start, !div_busy)
  `ASL_ASSERT_IMPLY(a_emit_slot_free, cmd.emit, !out_valid || out_ready)
  `ASL_ASSERT_NEXT(a_count_saturates, cmd.fold_finish && (count == asl_pkg::CNT_MAX), count == asl_pkg::CNT_MAX)
  `ASL_ASSERT_NEXT(a_emit_clears_count, cmd.emit, out_valid && (count == '0))

endmodule

`default_nettype wire

[rtl/asl_ctrl.sv]
// Controller state machine: sequences start marks, per-channel folds and
// record emission. Depends on asl_pkg for the command and status structs.
`default_nettype none

module asl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire asl_pkg::asl_sts_t sts,
  output asl_pkg::asl_cmd_t      cmd
);

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_DISPATCH   = 8'b0000_0010,
    S_MARK_SMP   = 8'b0000_0100,
    S_MARK_SAV   = 8'b0000_1000,
    S_FOLD_ISSUE = 8'b0001_0000,
    S_FOLD_WAIT  = 8'b0010_0000,
    S_CHECK      = 8'b0100_0000,
    S_EMIT       = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (sts.is_start) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = asl_pkg::DIV_MARK_SMP;
          state_next    = S_MARK_SMP;
        end else if (!sts.active) begin
          state_next = S_IDLE;
        end else if (sts.hit_sample) begin
          state_next = S_FOLD_ISSUE;
        end else begin
          state_next = S_CHECK;
        end
      end
      S_MARK_SMP: begin
        if (sts.div_done) begin
          cmd.mark_smp_write = 1'b1;
          cmd.div_start      = 1'b1;
          cmd.div_sel        = asl_pkg::DIV_MARK_SAV;
          state_next         = S_MARK_SAV;
        end
      end
      S_MARK_SAV: begin
        if (sts.div_done) begin
          cmd.mark_sav_write = 1'b1;
          cmd.start_finish   = 1'b1;
          state_next         = S_IDLE;
        end
      end
      S_FOLD_ISSUE: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = asl_pkg::DIV_FOLD;
        state_next    = S_FOLD_WAIT;
      end
      S_FOLD_WAIT: begin
        cmd.div_sel = asl_pkg::DIV_FOLD;
        if (sts.div_done) begin
          cmd.mean_write = 1'b1;
          cmd.ch_next    = 1'b1;
          if (sts.last_ch) begin
            cmd.fold_finish = 1'b1;
            state_next      = S_CHECK;
          end else begin
            state_next = S_FOLD_ISSUE;
          end
        end
      end
      S_CHECK: begin
        state_next = sts.hit_save ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[rtl/averaging_sample_logger.sv]
// Averaging sample logger: a cumulative moving average over seven 16-bit
// channels with minute-based sample and save marks. Top level; depends on
// asl_pkg, asl_ctrl, asl_dp (which holds asl_div).
//
// A start item (req_type 0) rounds the current minute up to the next
// multiple of the sample interval and of the save interval (a mark past
// minute 59 becomes 0), zeroes the sample count and arms the logger. A poll
// item (req_type 1) whose minute hits the sample mark folds each channel's
// sample into its mean, moving it by (new - mean)/(count + 1) rounded half
// away from zero, and advances that mark modulo 60. A poll whose minute hits
// the save mark emits one record with the poll's time and the means (after
// any fold from the same poll), then clears means and count. Polls before
// the first start are dropped without a record. An interval register that
// holds 0 acts as 1. Items are taken one at a time: in_ready is high only
// while the controller idles. In a poll that folds, one shared restoring
// divider (2 quotient bits per cycle, an issue state before each division)
// serves the seven channels in turn. A start runs two divisions for the
// marks. The record sits in an output register, so the next item is
// accepted while a record still waits for out_ready; only a second record
// stalls until the first is taken. Write the interval registers only while
// the block is idle.
`default_nettype none

module averaging_sample_logger (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [5:0]  cfg_data,
  // input items
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic [3:0]  month,
  input  wire logic [4:0]  day,
  input  wire logic [4:0]  hour,
  input  wire logic [5:0]  minute,
  input  wire logic [15:0] sample_ch0,
  input  wire logic [15:0] sample_ch1,
  input  wire logic [15:0] sample_ch2,
  input  wire logic [15:0] sample_ch3,
  input  wire logic [15:0] sample_ch4,
  input  wire logic [15:0] sample_ch5,
  input  wire logic [15:0] sample_ch6,
  // result items
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       rec_month,
  output logic [4:0]       rec_day,
  output logic [4:0]       rec_hour,
  output logic [5:0]       rec_minute,
  output logic [15:0]      mean_ch0,
  output logic [15:0]      mean_ch1,
  output logic [15:0]      mean_ch2,
  output logic [15:0]      mean_ch3,
  output logic [15:0]      mean_ch4,
  output logic [15:0]      mean_ch5,
  output logic [15:0]      mean_ch6
);

  asl_pkg::asl_cmd_t cmd;
  asl_pkg::asl_sts_t sts;
  asl_pkg::smp_vec_t samples;
  asl_pkg::smp_vec_t rec_mean;

  // Gather the channel ports into one vector, channel 0 at index 0.
  assign samples[0] = sample_ch0;
  assign samples[1] = sample_ch1;
  assign samples[2] = sample_ch2;
  assign samples[3] = sample_ch3;
  assign samples[4] = sample_ch4;
  assign samples[5] = sample_ch5;
  assign samples[6] = sample_ch6;

  // Controller: owns the handshake on the input side and the sequencing.
  asl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: state, divider and the record register with out_valid.
  asl_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req_type   (req_type),
    .month      (month),
    .day        (day),
    .hour       (hour),
    .minute     (minute),
    .samples    (samples),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .rec_month  (rec_month),
    .rec_day    (rec_day),
    .rec_hour   (rec_hour),
    .rec_minute (rec_minute),
    .rec_mean   (rec_mean)
  );

  // Split the record means back onto the channel ports.
  assign mean_ch0 = rec_mean[0];
  assign mean_ch1 = rec_mean[1];
  assign mean_ch2 = rec_mean[2];
  assign mean_ch3 = rec_mean[3];
  assign mean_ch4 = rec_mean[4];
  assign mean_ch5 = rec_mean[5];
  assign mean_ch6 = rec_mean[6];

endmodule

`default_nettype wire
